### sv/flptw_pkg.sv
// Shared types, constants and helpers for the four-level page table walker.
// No dependencies; imported by flptw_ctrl, flptw_dp and the top level.
package flptw_pkg;

  localparam int unsigned TABLE_WORDS_DEF = 65536;
  localparam int unsigned PA_W   = 52;
  localparam int unsigned VA_W   = 48;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned FRAME_W = 40;   // address bits 51..12
  localparam int unsigned WIDX_W = 16;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned SIZE_W = 2;
  localparam int unsigned LVL_W  = 2;
  // table word position: frame bits above a 9-bit index
  localparam int unsigned TWORD_W = FRAME_W + IDX_W;
  // stored table word: frame bits and present bit only
  localparam int unsigned ENTRY_W = FRAME_W + 1;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_4K = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_2M = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_1G = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;    // latch address and size of the accepted item
    logic store_wr;   // write table word from the input item
    logic issue;      // start a table memory read
    logic from_root;  // read address is based on the root table
    logic res_clear;  // result: zero address, no fault
    logic res_fault;  // result: fault
    logic res_pa;     // result: translated address
    logic load_out;   // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic in_window;  // read address being issued lies inside memory
    logic present;    // present bit of the word just read
    logic last;       // word just read is the final level for this size
  } sts_t;

  function automatic logic [LVL_W-1:0] last_level(input logic [SIZE_W-1:0] size);
    logic [LVL_W-1:0] lvl;
    unique case (size)
      SIZE_1G: lvl = 2'd1;
      SIZE_2M: lvl = 2'd2;
      default: lvl = 2'd3;
    endcase
    return lvl;
  endfunction

  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic logic [PA_W-1:0] page_offset(input logic [VA_W-1:0] va,
                                                  input logic [SIZE_W-1:0] size);
    logic [PA_W-1:0] off;
    unique case (size)
      SIZE_1G: off = PA_W'(va[29:0]);
      SIZE_2M: off = PA_W'(va[20:0]);
      default: off = PA_W'(va[11:0]);
    endcase
    return off;
  endfunction

endpackage

### sv/flptw_ctrl.sv
// Walk controller: state machine that sequences table reads and result hand-off.
// Depends on flptw_pkg; drives commands to flptw_dp and reads its status.
module flptw_ctrl
  import flptw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == KIND_STORE) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = sts.in_window ? ST_CHECK : ST_FINISH;
      end
      ST_CHECK: begin
        if (!sts.present || sts.last || !sts.in_window) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_kind == KIND_STORE) begin
            cmd.store_wr  = 1'b1;
            cmd.res_clear = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.issue     = 1'b1;
        cmd.from_root = 1'b1;
        cmd.res_fault = !sts.in_window;
      end
      ST_CHECK: begin
        if (!sts.present) begin
          cmd.res_fault = 1'b1;
        end else if (sts.last) begin
          cmd.res_pa = 1'b1;
        end else begin
          // chain straight into the next level's read
          cmd.issue     = 1'b1;
          cmd.res_fault = !sts.in_window;
        end
      end
      ST_FINISH: begin
        cmd.load_out = !out_valid_r || !out_stall;
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != ST_IDLE);

endmodule

### sv/flptw_dp.sv
// Walk datapath: table memory, root register, walk registers and result registers.
// Depends on flptw_pkg; steered by commands from flptw_ctrl.
module flptw_dp
  import flptw_pkg::*;
#(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [PA_W-1:0]   cfg_wr_data,
  input  logic [VA_W-1:0]   in_virtual_address,
  input  logic [SIZE_W-1:0] in_size_select,
  input  logic [WIDX_W-1:0] in_word_index,
  input  logic [WORD_W-1:0] in_word_value,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [PA_W-1:0]   out_phys_addr,
  output logic              out_fault
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);
  localparam logic [TWORD_W-1:0] WIN_LIMIT = TWORD_W'(TABLE_WORDS);
  localparam logic [31:0]        WR_LIMIT  = 32'(TABLE_WORDS);

  logic [ENTRY_W-1:0] mem [TABLE_WORDS];

  logic [FRAME_W-1:0] root_r;
  logic [VA_W-1:0]    va_r;
  logic [SIZE_W-1:0]  size_r;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [ENTRY_W-1:0] rdata_r;
  logic [PA_W-1:0]    res_pa_r, out_pa_r;
  logic               res_fault_r, out_fault_r;

  logic [FRAME_W-1:0] base;
  logic [TWORD_W-1:0] tword;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        widx_ext;
  logic [AW-1:0]      wr_addr;
  logic               wr_ok;
  logic [PA_W-1:0]    pa_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_wr_en) begin
      root_r <= cfg_wr_data[PA_W-1:12];
    end
  end

  // read address for the level about to be fetched
  assign lvl_nxt = cmd.from_root ? '0 : lvl_r + 2'd1;
  assign base    = cmd.from_root ? root_r : rdata_r[ENTRY_W-1:1];
  assign tword   = {base, level_index(va_r, lvl_nxt)};
  assign rd_addr = tword[AW-1:0];

  assign widx_ext = 32'(in_word_index);
  assign wr_addr  = widx_ext[AW-1:0];
  assign wr_ok    = widx_ext < WR_LIMIT;

  always_ff @(posedge clk) begin
    if (cmd.store_wr && wr_ok) begin
      mem[wr_addr] <= {in_word_value[PA_W-1:12], in_word_value[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rdata_r <= mem[rd_addr];
      lvl_r   <= lvl_nxt;
    end
    if (cmd.capture) begin
      va_r   <= in_virtual_address;
      size_r <= in_size_select;
    end
  end

  assign pa_sum = {rdata_r[ENTRY_W-1:1], 12'b0} + page_offset(va_r, size_r);

  always_ff @(posedge clk) begin
    if (cmd.res_clear || cmd.res_fault) begin
      res_pa_r    <= '0;
      res_fault_r <= cmd.res_fault;
    end else if (cmd.res_pa) begin
      res_pa_r    <= pa_sum;
      res_fault_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_pa_r    <= res_pa_r;
      out_fault_r <= res_fault_r;
    end
  end

  assign sts.in_window = tword < WIN_LIMIT;
  assign sts.present   = rdata_r[0];
  assign sts.last      = (lvl_r == last_level(size_r));

  assign out_phys_addr = out_pa_r;
  assign out_fault     = out_fault_r;

endmodule

### sv/four_level_page_table_walker_unit.sv
// Four-level page table walker: table memory of TABLE_WORDS words that store
// items fill, and translate items that walk it from the root register set
// through cfg_wr_en. A store item is accepted, then its result goes to the
// output register. A translation is accepted, issues the root read, makes one
// registered table memory read per level down to the last level of its page
// size and hands off the result, ending early on a fault. One item is in
// flight at a time; a finished result waits in the output register while the
// next item is taken. The memory has no reset; translating through words
// never stored gives undefined results.
module four_level_page_table_walker_unit
  import flptw_pkg::*;
#(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [PA_W-1:0]   cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [VA_W-1:0]   in_virtual_address,
  input  logic [SIZE_W-1:0] in_size_select,
  input  logic [WIDX_W-1:0] in_word_index,
  input  logic [WORD_W-1:0] in_word_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PA_W-1:0]   out_phys_addr,
  output logic              out_fault
);

  cmd_t cmd;
  sts_t sts;

  flptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  flptw_dp #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_virtual_address (in_virtual_address),
    .in_size_select     (in_size_select),
    .in_word_index      (in_word_index),
    .in_word_value      (in_word_value),
    .cmd                (cmd),
    .sts                (sts),
    .out_phys_addr      (out_phys_addr),
    .out_fault          (out_fault)
  );

endmodule
